// ===== rtl/ihp_pkg.sv =====
// Shared types, codes and command/status bundles for the indexed max-priority heap.
`default_nettype none
package ihp_pkg;

  localparam int NODE_W    = 10;
  localparam int SCORE_W   = 16;
  localparam int COUNT_W   = 11;
  localparam int NODE_SPAN = 1 << NODE_W;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_CHANGE = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef struct packed {
    mode_e                      mode;
    logic [NODE_W-1:0]          node_id;
    logic signed [SCORE_W-1:0]  node_score;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0]          head_node;
    logic signed [SCORE_W-1:0]  head_score;
    status_e                    status;
    logic                       node_present;
    logic [COUNT_W-1:0]         entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_ACCEPT,
    CMD_LOOK,
    CMD_REM,
    CMD_SWEEP,
    CMD_UP_A,
    CMD_UP_B,
    CMD_UP_C,
    CMD_DN_A,
    CMD_DN_B,
    CMD_DN_C,
    CMD_FIN,
    CMD_RESP
  } cmd_e;

  typedef struct packed {
    logic go_sift;
    logic go_rem;
    logic go_sweep;
    logic rem_more;
    logic sweep_done;
    logic pos_root;
    logic up_swap;
    logic no_left;
    logic dn_swap;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

// ===== rtl/ihp_ctrl.sv =====
// Sequencer for the heap: look-up, sift steps, clearing sweep and result hand-off.
`default_nettype none
module ihp_ctrl import ihp_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  st_t  st_i,
  output cmd_e cmd_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOOK, S_REM, S_SWEEP, S_UP_A, S_UP_B, S_UP_C,
    S_DN_A, S_DN_B, S_DN_C, S_FIN, S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = CMD_IDLE;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o = CMD_SWEEP;
        if (st_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o = CMD_LOOK;
        if (st_i.go_sweep)     state_d = S_SWEEP;
        else if (st_i.go_rem)  state_d = S_REM;
        else if (st_i.go_sift) state_d = S_UP_A;
        else                   state_d = S_RESP;
      end
      S_REM: begin
        cmd_o   = CMD_REM;
        state_d = st_i.rem_more ? S_UP_A : S_RESP;
      end
      S_SWEEP: begin
        cmd_o = CMD_SWEEP;
        if (st_i.sweep_done) state_d = S_RESP;
      end
      S_UP_A: begin
        cmd_o   = CMD_UP_A;
        state_d = st_i.pos_root ? S_DN_A : S_UP_B;
      end
      S_UP_B: begin
        cmd_o   = CMD_UP_B;
        state_d = S_UP_C;
      end
      S_UP_C: begin
        cmd_o   = CMD_UP_C;
        state_d = st_i.up_swap ? S_UP_A : S_DN_A;
      end
      S_DN_A: begin
        cmd_o   = CMD_DN_A;
        state_d = st_i.no_left ? S_FIN : S_DN_B;
      end
      S_DN_B: begin
        cmd_o   = CMD_DN_B;
        state_d = S_DN_C;
      end
      S_DN_C: begin
        cmd_o   = CMD_DN_C;
        state_d = st_i.dn_swap ? S_DN_A : S_FIN;
      end
      S_FIN: begin
        cmd_o   = CMD_FIN;
        state_d = S_RESP;
      end
      S_RESP: begin
        // hold until the result register can take the new result
        if (st_i.out_free) begin
          cmd_o   = CMD_RESP;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/ihp_dp.sv =====
// Heap datapath: slot, position and score memories, sift registers and result register.
`default_nettype none
module ihp_dp import ihp_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int SCORE_BITS = 16
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cmd_e  cmd_i,
  input  req_t  req_i,
  input  wire   out_stall_i,
  output st_t   st_o,
  output logic  out_valid_o,
  output rsp_t  out_rsp_o
);

  localparam int NODE_DEPTH = (CAPACITY < NODE_SPAN) ? CAPACITY : NODE_SPAN;
  localparam int IW = $clog2(NODE_DEPTH);
  localparam int CW = $clog2(NODE_DEPTH + 1);
  localparam longint SC_HI = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
  localparam longint SC_LO = -SC_HI - 1;

  // memories
  logic [IW-1:0]         slot_mem  [NODE_DEPTH];
  logic [CW-1:0]         pmap_mem  [NODE_DEPTH];
  logic [SCORE_BITS-1:0] score_mem [NODE_DEPTH];

  logic [IW-1:0]         slot_ra0, slot_ra1, slot_wa, slot_wd;
  logic [IW-1:0]         slot_rd0_q, slot_rd1_q;
  logic                  slot_we;
  logic [IW-1:0]         pmap_ra, pmap_wa;
  logic [CW-1:0]         pmap_wd, pmap_rd_q;
  logic                  pmap_we;
  logic [IW-1:0]         score_ra0, score_ra1, score_wa;
  logic [SCORE_BITS-1:0] score_wd, score_rd0_q, score_rd1_q;
  logic                  score_we;

  // control registers
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] sw_q, sw_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  mode_e                 mode_q, mode_d;
  logic [NODE_W-1:0]     node_q, node_d;
  logic [SCORE_BITS-1:0] sc_q, sc_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic [IW-1:0]         cur_n_q, cur_n_d;
  logic [SCORE_BITS-1:0] cur_s_q, cur_s_d;
  logic [IW-1:0]         nb_l_q, nb_l_d, nb_r_q, nb_r_d;
  logic [IW-1:0]         hnode_q, hnode_d;
  logic [SCORE_BITS-1:0] hscore_q, hscore_d;
  status_e               status_q, status_d;
  logic                  present_q, present_d;
  rsp_t                  out_q, out_d;

  logic [SCORE_BITS-1:0] fit_score;
  longint                raw_score;
  logic [IW-1:0]         node_idx, par;
  logic [CW:0]           lw, rw;
  logic                  no_left, r_in, take_r, take_l, in_range, present;

  // saturate the incoming score into the stored width
  always_comb begin
    raw_score = longint'($signed(req_i.node_score));
    if (raw_score > SC_HI)      fit_score = SCORE_BITS'(SC_HI);
    else if (raw_score < SC_LO) fit_score = SCORE_BITS'(SC_LO);
    else                        fit_score = SCORE_BITS'(raw_score);
  end

  assign node_idx = IW'(node_q);
  assign par      = IW'((pos_q - IW'(1)) >> 1);
  assign lw       = ((CW + 1)'(pos_q) << 1) | (CW + 1)'(1);
  assign rw       = lw + (CW + 1)'(1);
  assign no_left  = lw >= (CW + 1)'(count_q);
  assign r_in     = rw < (CW + 1)'(count_q);
  assign in_range = 32'(node_q) < CAPACITY;
  assign present  = in_range && (pmap_rd_q != '0);
  assign take_r   = r_in && ($signed(cur_s_q) < $signed(score_rd1_q))
                    && ($signed(score_rd1_q) >= $signed(score_rd0_q));
  assign take_l   = $signed(cur_s_q) < $signed(score_rd0_q);

  always_comb begin
    slot_ra0  = '0;
    slot_ra1  = '0;
    pmap_ra   = '0;
    score_ra0 = '0;
    score_ra1 = '0;
    slot_we   = 1'b0;
    slot_wa   = pos_q;
    slot_wd   = cur_n_q;
    pmap_we   = 1'b0;
    pmap_wa   = cur_n_q;
    pmap_wd   = CW'(pos_q) + CW'(1);
    score_we  = 1'b0;
    score_wa  = node_idx;
    score_wd  = sc_q;

    count_d   = count_q;
    sw_d      = sw_q;
    mode_d    = mode_q;
    node_d    = node_q;
    sc_d      = sc_q;
    pos_d     = pos_q;
    cur_n_d   = cur_n_q;
    cur_s_d   = cur_s_q;
    nb_l_d    = nb_l_q;
    nb_r_d    = nb_r_q;
    hnode_d   = hnode_q;
    hscore_d  = hscore_q;
    status_d  = status_q;
    present_d = present_q;
    st_o      = '0;

    unique case (cmd_i)
      CMD_ACCEPT: begin
        mode_d   = req_i.mode;
        node_d   = req_i.node_id;
        sc_d     = fit_score;
        pmap_ra  = IW'(req_i.node_id);
        slot_ra0 = '0;
        slot_ra1 = IW'(count_q - CW'(1));
      end
      CMD_LOOK: begin
        present_d = present;
        hnode_d   = '0;
        hscore_d  = '0;
        status_d  = ST_OK;
        unique case (mode_q)
          MODE_INSERT: begin
            if (32'(count_q) >= CAPACITY) begin
              status_d = ST_FULL;
            end else if (!in_range) begin
              status_d = ST_ABSENT;
            end else if (present) begin
              status_d = ST_DUP;
            end else begin
              score_we      = 1'b1;
              cur_n_d       = node_idx;
              cur_s_d       = sc_q;
              pos_d         = IW'(count_q);
              count_d       = count_q + CW'(1);
              st_o.go_sift  = 1'b1;
            end
          end
          MODE_CHANGE: begin
            if (!present) begin
              status_d = ST_ABSENT;
            end else begin
              score_we     = 1'b1;
              cur_n_d      = node_idx;
              cur_s_d      = sc_q;
              pos_d        = IW'(pmap_rd_q - CW'(1));
              st_o.go_sift = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              // drop the head, move the last entry to the root
              hnode_d     = slot_rd0_q;
              pmap_we     = 1'b1;
              pmap_wa     = slot_rd0_q;
              pmap_wd     = '0;
              count_d     = count_q - CW'(1);
              cur_n_d     = slot_rd1_q;
              pos_d       = '0;
              score_ra0   = slot_rd0_q;
              score_ra1   = slot_rd1_q;
              st_o.go_rem = 1'b1;
            end
          end
          MODE_CLEAR: begin
            count_d       = '0;
            sw_d          = '0;
            st_o.go_sweep = 1'b1;
          end
          default: status_d = ST_OK;
        endcase
      end
      CMD_REM: begin
        hscore_d      = score_rd0_q;
        cur_s_d       = score_rd1_q;
        st_o.rem_more = (count_q != '0);
      end
      CMD_SWEEP: begin
        pmap_we         = 1'b1;
        pmap_wa         = sw_q;
        pmap_wd         = '0;
        st_o.sweep_done = (sw_q == IW'(NODE_DEPTH - 1));
        sw_d            = st_o.sweep_done ? '0 : sw_q + IW'(1);
      end
      CMD_UP_A: begin
        slot_ra0      = par;
        st_o.pos_root = (pos_q == '0);
      end
      CMD_UP_B: begin
        nb_l_d    = slot_rd0_q;
        score_ra0 = slot_rd0_q;
      end
      CMD_UP_C: begin
        if ($signed(cur_s_q) > $signed(score_rd0_q)) begin
          st_o.up_swap = 1'b1;
          slot_we      = 1'b1;
          slot_wd      = nb_l_q;
          pmap_we      = 1'b1;
          pmap_wa      = nb_l_q;
          pos_d        = par;
        end
      end
      CMD_DN_A: begin
        st_o.no_left = no_left;
        slot_ra0     = IW'(lw);
        slot_ra1     = IW'(rw);
      end
      CMD_DN_B: begin
        nb_l_d    = slot_rd0_q;
        nb_r_d    = slot_rd1_q;
        score_ra0 = slot_rd0_q;
        score_ra1 = slot_rd1_q;
      end
      CMD_DN_C: begin
        if (take_r) begin
          st_o.dn_swap = 1'b1;
          slot_we      = 1'b1;
          slot_wd      = nb_r_q;
          pmap_we      = 1'b1;
          pmap_wa      = nb_r_q;
          pos_d        = IW'(rw);
        end else if (take_l) begin
          st_o.dn_swap = 1'b1;
          slot_we      = 1'b1;
          slot_wd      = nb_l_q;
          pmap_we      = 1'b1;
          pmap_wa      = nb_l_q;
          pos_d        = IW'(lw);
        end
      end
      CMD_FIN: begin
        // settle the moving entry at its final slot
        slot_we = 1'b1;
        pmap_we = 1'b1;
      end
      default: ;
    endcase

    st_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i == CMD_RESP) begin
      out_valid_d        = 1'b1;
      out_d.head_node    = NODE_W'(hnode_q);
      out_d.head_score   = SCORE_W'($signed(hscore_q));
      out_d.status       = status_q;
      out_d.node_present = present_q;
      out_d.entry_count  = COUNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd0_q <= slot_mem[slot_ra0];
    slot_rd1_q <= slot_mem[slot_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (pmap_we) pmap_mem[pmap_wa] <= pmap_wd;
    pmap_rd_q <= pmap_mem[pmap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (score_we) score_mem[score_wa] <= score_wd;
    score_rd0_q <= score_mem[score_ra0];
    score_rd1_q <= score_mem[score_ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    node_q    <= node_d;
    sc_q      <= sc_d;
    pos_q     <= pos_d;
    cur_n_q   <= cur_n_d;
    cur_s_q   <= cur_s_d;
    nb_l_q    <= nb_l_d;
    nb_r_q    <= nb_r_d;
    hnode_q   <= hnode_d;
    hscore_q  <= hscore_d;
    status_q  <= status_d;
    present_q <= present_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NODE_DEPTH))
    else $error("entry count beyond storage depth");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_RESP) |=> out_valid_q)
    else $error("result not presented after hand-off");

  a_count_only_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i != CMD_LOOK) |=> $stable(count_q))
    else $error("entry count changed outside look-up");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_UP_C && st_o.up_swap) |-> (pos_q != '0))
    else $error("upward swap from the root");
`endif

endmodule
`default_nettype wire

// ===== rtl/indexed_max_priority_heap.sv =====
// Top level of the indexed max-priority heap: sequencer plus datapath.
// Indexed binary max-heap of node ids keyed by signed scores. One request is worked on at a
// time; the result register lets the next request in while a result still waits. A rejected
// request goes through accept, look-up and hand-off. An insert or change then climbs, each
// level a parent slot read, a parent score read and a compare (skipped at the root), and
// descends, each level a child slot read, a child score read and a compare (none where there
// is no left child), and ends with a step to settle the moving entry. Remove head adds a step
// to fetch the scores, and goes straight to hand-off when it leaves the heap empty. Each sift
// step waits on the registered reads of the slot and score memories. Clear sweeps the
// position map one entry a cycle over min(CAPACITY, 1024) entries, then hands off, and the
// same sweep runs once after reset before the first request is taken. The hand-off also waits
// while an earlier result is still stalled.
`default_nettype none
module indexed_max_priority_heap import ihp_pkg::*; #(
  parameter int CAPACITY   = 1024,
  parameter int SCORE_BITS = 16
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_e cmd;
  st_t  st;

  ihp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ihp_dp #(
    .CAPACITY   (CAPACITY),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .out_stall_i (out_stall_i),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire
